FILE: rtl/msb_first_bit_unpacker_assert.svh
`ifndef MSB_FIRST_BIT_UNPACKER_ASSERT_SVH
`define MSB_FIRST_BIT_UNPACKER_ASSERT_SVH

// antecedent and consequent checked in the same cycle
`define MSBU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MSBU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/msbu_pkg.sv
package msbu_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int BUF_BITS     = 15;
    localparam int NBITS_W      = 4;
    localparam int WIDTH_W      = 4;
    localparam int COUNT_W      = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int MAX_ELEMENTS = 1024;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_BITS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_COUNT = 2'd1;

    localparam logic [WIDTH_W-1:0] RESET_WIDTH = 4'd8;
    localparam logic [COUNT_W-1:0] RESET_COUNT = 11'd256;

    // effective configuration plus a one-cycle string clear
    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [COUNT_W-1:0] count;
        logic               clear;
    } t_cfg;

    // one held input byte
    typedef struct packed {
        logic                 valid;
        logic [BYTE_BITS-1:0] data;
    } t_beat;

    // width register: zero reads as one, above a byte saturates
    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] raw);
        logic [WIDTH_W-1:0] w;
        w = raw;
        if (raw == '0) begin
            w = WIDTH_W'(1);
        end else if (raw > WIDTH_W'(BYTE_BITS)) begin
            w = WIDTH_W'(BYTE_BITS);
        end
        return w;
    endfunction

    // count register: zero reads as one, saturates at the maximum
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] raw);
        logic [COUNT_W-1:0] c;
        c = raw;
        if (raw == '0) begin
            c = COUNT_W'(1);
        end else if (raw > COUNT_W'(MAX_ELEMENTS)) begin
            c = COUNT_W'(MAX_ELEMENTS);
        end
        return c;
    endfunction

    // low ones mask for an element of w bits, w in 1..8
    function automatic logic [BYTE_BITS-1:0] elem_mask(input logic [WIDTH_W-1:0] w);
        logic [BYTE_BITS:0] m;
        m = ((BYTE_BITS+1)'(1) << w) - (BYTE_BITS+1)'(1);
        return m[BYTE_BITS-1:0];
    endfunction

endpackage

FILE: rtl/msbu_cfg.sv
module msbu_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [msbu_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [msbu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output msbu_pkg::t_cfg                   o_cfg
);

    logic [msbu_pkg::WIDTH_W-1:0] r_width;
    logic [msbu_pkg::COUNT_W-1:0] r_count;
    logic                         wr;
    logic                         hit_width;
    logic                         hit_count;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid && o_cfg_ready;
    assign hit_width   = wr && (i_cfg_index == msbu_pkg::REG_ELEMENT_BITS);
    assign hit_count   = wr && (i_cfg_index == msbu_pkg::REG_ELEMENT_COUNT);

    // effective values are stored, so the datapath never clamps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= msbu_pkg::RESET_WIDTH;
            r_count <= msbu_pkg::RESET_COUNT;
        end else begin
            if (hit_width) begin
                r_width <= msbu_pkg::eff_width(i_cfg_data[msbu_pkg::WIDTH_W-1:0]);
            end
            if (hit_count) begin
                r_count <= msbu_pkg::eff_count(i_cfg_data[msbu_pkg::COUNT_W-1:0]);
            end
        end
    end

    assign o_cfg.width = r_width;
    assign o_cfg.count = r_count;
    // a write to a known register restarts the string at the same edge
    assign o_cfg.clear = hit_width || hit_count;

endmodule

FILE: rtl/msbu_in_stage.sv
module msbu_in_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [msbu_pkg::BYTE_BITS-1:0] i_packed_byte,
    output msbu_pkg::t_beat                o_beat,
    input  logic                           i_take
);

    logic                           r_valid;
    logic [msbu_pkg::BYTE_BITS-1:0] r_byte;
    logic                           accept;

    // hold off new beats while the held byte is not yet merged
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_take);
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_packed_byte;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_byte;

endmodule

FILE: rtl/msbu_extract.sv
module msbu_extract (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  msbu_pkg::t_cfg                 i_cfg,
    input  msbu_pkg::t_beat                i_beat,
    output logic                           o_take,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [msbu_pkg::BYTE_BITS-1:0] o_element_value,
    output logic                           o_last_element
);

    logic [msbu_pkg::BUF_BITS-1:0]  r_buf,   n_buf;
    logic [msbu_pkg::NBITS_W-1:0]   r_nbits, n_nbits;
    logic [msbu_pkg::COUNT_W-1:0]   r_done,  n_done;
    logic                           r_out_valid;
    logic [msbu_pkg::BYTE_BITS-1:0] r_out_value;
    logic                           r_out_last;

    logic                           have;
    logic                           fire;
    logic [msbu_pkg::NBITS_W-1:0]   shift;
    logic [msbu_pkg::BYTE_BITS-1:0] elem;
    logic [msbu_pkg::COUNT_W-1:0]   done_inc;
    logic                           is_last;
    logic [msbu_pkg::BUF_BITS-1:0]  post_buf;
    logic [msbu_pkg::NBITS_W-1:0]   post_nbits;
    logic [msbu_pkg::COUNT_W-1:0]   post_done;

    // one element leaves the buffer per cycle when the result register frees
    assign have     = r_nbits >= i_cfg.width;
    assign fire     = have && (!r_out_valid || !i_out_stall);
    assign shift    = r_nbits - i_cfg.width;
    assign elem     = msbu_pkg::BYTE_BITS'(r_buf >> shift) & msbu_pkg::elem_mask(i_cfg.width);
    assign done_inc = r_done + msbu_pkg::COUNT_W'(1);
    assign is_last  = done_inc >= i_cfg.count;

    // buffer state once this cycle's element is out
    always_comb begin
        post_buf   = r_buf;
        post_nbits = r_nbits;
        post_done  = r_done;
        if (fire) begin
            if (is_last) begin
                // trailing bits are dropped and a new string begins
                post_buf   = '0;
                post_nbits = '0;
                post_done  = '0;
            end else begin
                post_buf   = r_buf & ((msbu_pkg::BUF_BITS'(1) << shift)
                                      - msbu_pkg::BUF_BITS'(1));
                post_nbits = shift;
                post_done  = done_inc;
            end
        end
    end

    // the held byte joins once no whole element is left
    assign o_take = i_beat.valid && (post_nbits < i_cfg.width);

    always_comb begin
        n_buf   = post_buf;
        n_nbits = post_nbits;
        n_done  = post_done;
        if (o_take) begin
            n_buf   = msbu_pkg::BUF_BITS'({post_buf, i_beat.data});
            n_nbits = post_nbits + msbu_pkg::NBITS_W'(msbu_pkg::BYTE_BITS);
        end
        if (i_cfg.clear) begin
            n_buf   = '0;
            n_nbits = '0;
            n_done  = '0;
        end
    end

    // bit buffer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_nbits <= '0;
            r_done  <= '0;
        end else begin
            r_buf   <= n_buf;
            r_nbits <= n_nbits;
            r_done  <= n_done;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_value <= elem;
            r_out_last  <= is_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_element_value = r_out_value;
    assign o_last_element  = r_out_last;

endmodule

FILE: rtl/msb_first_bit_unpacker.sv
// an accepted input beat passes the input register and the bit buffer before its first result beat is offered
// throughput: one byte per cycle while each byte gives at most one element and the
//   output does not stall; otherwise each byte is held back while its elements drain
//   through the single result register, which sends one element a cycle
// reset (synchronous, active low): bit buffer, counts and valids clear,
//   element width returns to 8 and element count to 256
module msb_first_bit_unpacker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [msbu_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [msbu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [msbu_pkg::BYTE_BITS-1:0]   i_packed_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [msbu_pkg::BYTE_BITS-1:0]   o_element_value,
    output logic                             o_last_element
);

    msbu_pkg::t_cfg  cfg;
    msbu_pkg::t_beat beat;
    logic            take;

    // configuration registers
    msbu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register
    msbu_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_packed_byte (i_packed_byte),
        .o_beat        (beat),
        .i_take        (take)
    );

    // bit buffer, element cut and result register
    msbu_extract u_extract (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_beat          (beat),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_element_value (o_element_value),
        .o_last_element  (o_last_element)
    );

endmodule

FILE: rtl/msbu_checker.sv
`include "msb_first_bit_unpacker_assert.svh"

module msbu_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [msbu_pkg::BYTE_BITS-1:0] o_element_value,
    input logic                           o_last_element
);

    logic out_held;

    assign out_held = o_out_valid && i_out_stall;

    // a stalled result beat keeps its payload
    `MSBU_ASSERT_NEXT(a_out_hold, out_held,
        o_out_valid && $stable(o_element_value) && $stable(o_last_element),
        "result beat changed while stalled")

    // input stalls only while elements are pending, so a result beat follows
    `MSBU_ASSERT_NEXT(a_stall_means_work, o_in_stall, o_out_valid,
        "input stalled with no result beat to follow")

    // the input side starts stalling only right after taking a beat
    `MSBU_ASSERT_SAME(a_stall_after_beat, $rose(o_in_stall), $past(i_in_valid),
        "input stall rose without a preceding input beat")

endmodule

bind msb_first_bit_unpacker msbu_checker u_msbu_checker (.*);
